[rtl/twmd_pkg.sv]
// Shared constants, types and state encodings for the window median door detector.
package twmd_pkg;

    localparam int WINDOW      = 20;
    localparam int SAMPLE_BITS = 16;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int ADDR_W = $clog2(2 * WINDOW);
    localparam int CMP_W  = SAMPLE_BITS + 2;

    localparam int DIST_W     = 15;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int FAR_W      = ((SAMPLE_BITS > DIST_W) ? SAMPLE_BITS : DIST_W) + 1;

    localparam logic [IDX_W-1:0]  MID_IDX   = IDX_W'(WINDOW / 2);
    localparam logic [IDX_W-1:0]  TOP_IDX   = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(WINDOW);
    localparam logic [ADDR_W-1:0] Y_BASE    = ADDR_W'(WINDOW);

    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_DISTANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT    = CFG_IDX_W'(1);

    localparam logic [DIST_W-1:0]  DIST_RESET  = DIST_W'(1200);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_TOP,
        S_RD_MID,
        S_DECIDE,
        S_SHIFT,
        S_RD_MED,
        S_GET_MED,
        S_NEXT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_sts_t;

endpackage

[rtl/trimmed_window_median_door_detect.sv]
// Top level: channels, config registers, commit of medians and door detector state.
//
// Trimmed sliding-window median with door detection.
// Input channel (in_valid/in_ready) takes one word: sample_x, sample_y, door_wait.
// Output channel (out_valid/out_ready) gives one word per input word: median_x,
// median_y, window_full, door_is_open.
// Config channel (cfg_valid/cfg_ready, always ready) writes door_distance_mm at
// index 0 and open_count_limit at index 1; other indexes are ignored. Write only
// while the block is idle.
// One input word is worked on at a time; in_ready is low until its result is
// committed. Both axes go through one window store and one comparator in turn.
// Fill phase: each axis runs START, the insertion walk in SHIFT and NEXT; the walk
// shifts at most fill count entries. Full phase: each axis runs START, RD_TOP,
// RD_MID, DECIDE, the walk in SHIFT, RD_MED, GET_MED and NEXT; the replaced
// extreme walks past 0 .. WINDOW-1 entries. The insertion walk runs one entry per
// cycle on the store's single read port.
// The result sits in the output register; if the receiver stalls, the next word
// may still be accepted and processed, and its commit waits until the held word
// is taken.
// Reset clears fill count, medians, door flag, counter and restores the config
// defaults; window contents are left as is and are refilled before being read.
module trimmed_window_median_door_detect
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0]   sample_x,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0]   sample_y,
    input  logic                                      door_wait,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0]   median_x,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0]   median_y,
    output logic                                      window_full,
    output logic                                      door_is_open,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [twmd_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [twmd_pkg::CFG_DATA_W-1:0]           cfg_data
);

    // config registers
    logic [twmd_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic [twmd_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // block state; also drives the output word directly
    logic [twmd_pkg::CNT_W-1:0]              fill_reg, fill_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] medx_reg, medx_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] medy_reg, medy_next;
    logic                                    door_reg, door_next;
    logic [twmd_pkg::LIMIT_W-1:0]            far_reg, far_next;
    logic                                    out_valid_reg, out_valid_next;

    // accepted input word
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] sx_reg, sy_reg;
    logic                                    wait_reg;

    twmd_pkg::seq_ctl_t ctl;
    twmd_pkg::seq_sts_t sts;

    logic signed [twmd_pkg::SAMPLE_BITS-1:0] seq_med_x, seq_med_y;
    logic                                    ram_we;
    logic [twmd_pkg::ADDR_W-1:0]             ram_waddr, ram_raddr;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

    logic                                    in_fire;
    logic                                    commit;
    logic                                    full_phase;
    logic signed [twmd_pkg::FAR_W-1:0]       sx_far, dist_far;
    logic                                    far;
    logic [twmd_pkg::LIMIT_W-1:0]            cnt;
    logic                                    flag;

    assign in_ready   = sts.idle;
    assign in_fire    = in_valid && in_ready;
    assign full_phase = (fill_reg == twmd_pkg::FILL_FULL);

    // commit only when the output register is free or being emptied
    assign commit = sts.done && (!out_valid_reg || out_ready);
    assign ctl    = '{start: in_fire, ack: commit};

    twmd_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .full_phase (full_phase),
        .fill_count (fill_reg),
        .samp_x     (sx_reg),
        .samp_y     (sy_reg),
        .sts        (sts),
        .med_x      (seq_med_x),
        .med_y      (seq_med_y),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    twmd_win_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // far reading: raw x strictly above the distance threshold
    assign sx_far   = twmd_pkg::FAR_W'(sx_reg);
    assign dist_far = twmd_pkg::FAR_W'(dist_reg);
    assign far      = sx_far > dist_far;

    // door detector, evaluated on full-phase commits only
    always_comb
    begin
        cnt  = far_reg;
        flag = door_reg;
        if (far)
        begin
            if (wait_reg)
            begin
                if (!flag)
                begin
                    cnt = far_reg + 1'b1;
                end
            end
            else
            begin
                flag = 1'b0;
                cnt  = '0;
            end
        end
        else
        begin
            flag = 1'b0;
        end
        if (cnt >= limit_reg)
        begin
            flag = 1'b1;
            cnt  = '0;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        medx_next = medx_reg;
        medy_next = medy_reg;
        door_next = door_reg;
        far_next  = far_reg;
        if (commit)
        begin
            if (full_phase)
            begin
                medx_next = seq_med_x;
                medy_next = seq_med_y;
                door_next = flag;
                far_next  = cnt;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        dist_next  = dist_reg;
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                twmd_pkg::CFG_DOOR_DISTANCE: dist_next  = cfg_data[twmd_pkg::DIST_W-1:0];
                twmd_pkg::CFG_OPEN_LIMIT:    limit_next = cfg_data[twmd_pkg::LIMIT_W-1:0];
                default:                     dist_next  = dist_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg      <= twmd_pkg::DIST_RESET;
            limit_reg     <= twmd_pkg::LIMIT_RESET;
            fill_reg      <= '0;
            medx_reg      <= '0;
            medy_reg      <= '0;
            door_reg      <= 1'b0;
            far_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dist_reg      <= dist_next;
            limit_reg     <= limit_next;
            fill_reg      <= fill_next;
            medx_reg      <= medx_next;
            medy_reg      <= medy_next;
            door_reg      <= door_next;
            far_reg       <= far_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sx_reg   <= sample_x;
            sy_reg   <= sample_y;
            wait_reg <= door_wait;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_x     = medx_reg;
    assign median_y     = medy_reg;
    assign window_full  = full_phase;
    assign door_is_open = door_reg;

endmodule

[rtl/twmd_win_ram.sv]
// Sample store for both sorted windows: one write port, one registered read port.
module twmd_win_ram
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [twmd_pkg::ADDR_W-1:0]           waddr,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0] wdata,
    input  logic [twmd_pkg::ADDR_W-1:0]           raddr,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0] rdata
);

    // x window at 0..WINDOW-1, y window at WINDOW..2*WINDOW-1
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] mem [0:2*twmd_pkg::WINDOW-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/twmd_seq.sv]
// Sequencer that walks both windows with one shared comparator: insert, replace extreme, median.
module twmd_seq
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  twmd_pkg::seq_ctl_t                      ctl,
    input  logic                                    full_phase,
    input  logic [twmd_pkg::CNT_W-1:0]              fill_count,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0] samp_x,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0] samp_y,
    output twmd_pkg::seq_sts_t                      sts,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0] med_x,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0] med_y,
    output logic                                    ram_we,
    output logic [twmd_pkg::ADDR_W-1:0]             ram_waddr,
    output logic signed [twmd_pkg::SAMPLE_BITS-1:0] ram_wdata,
    output logic [twmd_pkg::ADDR_W-1:0]             ram_raddr,
    input  logic signed [twmd_pkg::SAMPLE_BITS-1:0] ram_rdata
);

    twmd_pkg::seq_state_t state_reg, state_next;
    logic                              axis_reg, axis_next;
    logic                              up_reg, up_next;
    logic [twmd_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] top_reg, top_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] medx_reg, medx_next;
    logic signed [twmd_pkg::SAMPLE_BITS-1:0] medy_reg, medy_next;

    logic signed [twmd_pkg::SAMPLE_BITS-1:0] val;
    logic signed [twmd_pkg::CMP_W-1:0]       cmp_a, cmp_b;
    logic                                    cmp_gt;
    logic                                    shift_go;
    logic [twmd_pkg::IDX_W-1:0]              rd_idx, wr_idx;
    logic [twmd_pkg::IDX_W:0]                idx_up2;

    assign val     = axis_reg ? samp_y : samp_x;
    assign idx_up2 = {1'b0, idx_reg} + (twmd_pkg::IDX_W + 1)'(2);

    // shared comparator: extreme choice in DECIDE, insertion walk in SHIFT
    always_comb
    begin
        if (state_reg == twmd_pkg::S_DECIDE)
        begin
            // (top - mid) > (mid - min)  <=>  top + min > 2 * mid
            cmp_a = twmd_pkg::CMP_W'(top_reg) + twmd_pkg::CMP_W'(min_reg);
            cmp_b = twmd_pkg::CMP_W'(ram_rdata) + twmd_pkg::CMP_W'(ram_rdata);
        end
        else if (up_reg)
        begin
            cmp_a = twmd_pkg::CMP_W'(ram_rdata);
            cmp_b = twmd_pkg::CMP_W'(val);
        end
        else
        begin
            cmp_a = twmd_pkg::CMP_W'(val);
            cmp_b = twmd_pkg::CMP_W'(ram_rdata);
        end
    end

    assign cmp_gt   = cmp_a > cmp_b;
    assign shift_go = up_reg ? ((idx_reg != '0) && cmp_gt)
                             : ((idx_reg != twmd_pkg::TOP_IDX) && cmp_gt);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twmd_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = twmd_pkg::S_START;
                end
            end
            twmd_pkg::S_START:
            begin
                state_next = full_phase ? twmd_pkg::S_RD_TOP : twmd_pkg::S_SHIFT;
            end
            twmd_pkg::S_RD_TOP:  state_next = twmd_pkg::S_RD_MID;
            twmd_pkg::S_RD_MID:  state_next = twmd_pkg::S_DECIDE;
            twmd_pkg::S_DECIDE:  state_next = twmd_pkg::S_SHIFT;
            twmd_pkg::S_SHIFT:
            begin
                if (!shift_go)
                begin
                    state_next = full_phase ? twmd_pkg::S_RD_MED : twmd_pkg::S_NEXT;
                end
            end
            twmd_pkg::S_RD_MED:  state_next = twmd_pkg::S_GET_MED;
            twmd_pkg::S_GET_MED: state_next = twmd_pkg::S_NEXT;
            twmd_pkg::S_NEXT:
            begin
                state_next = axis_reg ? twmd_pkg::S_DONE : twmd_pkg::S_START;
            end
            twmd_pkg::S_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = twmd_pkg::S_IDLE;
                end
            end
            default:             state_next = twmd_pkg::S_IDLE;
        endcase
    end

    // memory controls and status
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        rd_idx    = '0;
        wr_idx    = idx_reg;
        case (state_reg)
            twmd_pkg::S_START:
            begin
                if (!full_phase && (fill_count != '0))
                begin
                    rd_idx = twmd_pkg::IDX_W'(fill_count - 1'b1);
                end
            end
            twmd_pkg::S_RD_TOP:  rd_idx = twmd_pkg::TOP_IDX;
            twmd_pkg::S_RD_MID:  rd_idx = twmd_pkg::MID_IDX;
            twmd_pkg::S_DECIDE:
            begin
                rd_idx = cmp_gt ? (twmd_pkg::TOP_IDX - 1'b1) : twmd_pkg::IDX_W'(1);
            end
            twmd_pkg::S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_wdata = shift_go ? ram_rdata : val;
                // prefetch the neighbor after next so the walk runs one entry a cycle
                if (up_reg)
                begin
                    rd_idx = (idx_reg >= twmd_pkg::IDX_W'(2)) ? (idx_reg - twmd_pkg::IDX_W'(2)) : '0;
                end
                else
                begin
                    rd_idx = (idx_up2 <= {1'b0, twmd_pkg::TOP_IDX})
                           ? idx_up2[twmd_pkg::IDX_W-1:0] : twmd_pkg::TOP_IDX;
                end
            end
            twmd_pkg::S_RD_MED:  rd_idx = twmd_pkg::MID_IDX;
            default:             rd_idx = '0;
        endcase
        sts.idle = (state_reg == twmd_pkg::S_IDLE);
        sts.done = (state_reg == twmd_pkg::S_DONE);
    end

    assign ram_raddr = twmd_pkg::ADDR_W'(rd_idx) + (axis_reg ? twmd_pkg::Y_BASE : '0);
    assign ram_waddr = twmd_pkg::ADDR_W'(wr_idx) + (axis_reg ? twmd_pkg::Y_BASE : '0);

    // datapath registers
    always_comb
    begin
        axis_next = axis_reg;
        up_next   = up_reg;
        idx_next  = idx_reg;
        min_next  = min_reg;
        top_next  = top_reg;
        medx_next = medx_reg;
        medy_next = medy_reg;
        case (state_reg)
            twmd_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    axis_next = 1'b0;
                end
            end
            twmd_pkg::S_START:
            begin
                up_next  = 1'b1;
                idx_next = twmd_pkg::IDX_W'(fill_count);
            end
            twmd_pkg::S_RD_TOP:  min_next = ram_rdata;
            twmd_pkg::S_RD_MID:  top_next = ram_rdata;
            twmd_pkg::S_DECIDE:
            begin
                up_next  = cmp_gt;
                idx_next = cmp_gt ? twmd_pkg::TOP_IDX : '0;
            end
            twmd_pkg::S_SHIFT:
            begin
                if (shift_go)
                begin
                    idx_next = up_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                end
            end
            twmd_pkg::S_GET_MED:
            begin
                if (axis_reg)
                begin
                    medy_next = ram_rdata;
                end
                else
                begin
                    medx_next = ram_rdata;
                end
            end
            twmd_pkg::S_NEXT:    axis_next = 1'b1;
            default:             axis_next = axis_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twmd_pkg::S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg   <= up_next;
        idx_reg  <= idx_next;
        min_reg  <= min_next;
        top_reg  <= top_next;
        medx_reg <= medx_next;
        medy_reg <= medy_next;
    end

    assign med_x = medx_reg;
    assign med_y = medy_reg;

endmodule

[rtl/twmd_check.sv]
// Port-level checks for the window median door detector, bound to the top level.
module twmd_check
(
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_ready,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic signed [twmd_pkg::SAMPLE_BITS-1:0]   median_x,
    input logic signed [twmd_pkg::SAMPLE_BITS-1:0]   median_y,
    input logic                                      window_full,
    input logic                                      door_is_open
);

    // a held result word does not change under a stall
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_x) && $stable(median_y)
            && $stable(window_full) && $stable(door_is_open))
        else $error("output word changed while stalled");

    // one word in flight: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word while the previous one was in work");

    // medians stay zero until the window is full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> (median_x == '0) && (median_y == '0))
        else $error("median given before the window filled");

    // the door detector does not run during the fill
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> !door_is_open)
        else $error("door open during window fill");

endmodule

bind trimmed_window_median_door_detect twmd_check u_twmd_check (.*);
